[hdl/rse_pkg.sv]
package rse_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int KEY_W = 32;
    localparam int PAY_W = 32;
    localparam int REC_W = KEY_W + PAY_W;

    typedef logic [1:0] algo_t;
    localparam algo_t ALGO_BUBBLE    = 2'd0;
    localparam algo_t ALGO_SELECTION = 2'd1;
    localparam algo_t ALGO_INSERTION = 2'd2;
    localparam algo_t ALGO_NONE      = 2'd3;

    typedef enum logic [8:0] {
        ST_LOAD   = 9'b000000001,
        ST_RD_A   = 9'b000000010,
        ST_RD_B   = 9'b000000100,
        ST_CMP    = 9'b000001000,
        ST_WR_A   = 9'b000010000,
        ST_WR_B   = 9'b000100000,
        ST_NEXT   = 9'b001000000,
        ST_OUT_RD = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    // signed a > b
    function automatic logic key_gt(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        key_gt = $signed(a) > $signed(b);
    endfunction

endpackage

[hdl/record_sort_engine_top.sv]
// record_sort_engine_top: collects records and emits them sorted by key.
// Input word (s_axis): tdata = {payload, key}, tlast marks the last record.
// Output word (m_axis): tdata = {payload_res, key_res}, tlast = last_res,
// tuser = dropped (set on every word of a set that lost records).
// algorithm (2 bits, via cfg_we/cfg_wdata): 0 bubble, 1 selection,
// 2 insertion, 3 arrival order. Write only while idle.
// Records are stored into a 64-entry memory, one per cycle while loading.
// After tlast the block stops taking words and sorts with one comparator,
// one read port and one write port. Bubble: each compare reads two records
// and writes them back swapped when out of order. Selection: each pass scans
// for the minimum and then swaps it into place. Insertion: larger records
// shift up to make room for each key. Sets of one record or mode 3 skip sorting.
// Each output word is loaded only after the previous one is taken.
// Records past capacity are discarded and flagged.
// The output register holds a word until m_axis_tready; the sequencer
// waits while the receiver stalls. Reset clears count, flag, state and
// the algorithm register; memory contents are not reset.
module record_sort_engine_top
    import rse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[31:0], payload[63:32]
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // key_res[31:0], payload_res[63:32]
    output logic        m_axis_tlast,   // last_res
    output logic        m_axis_tuser    // dropped
);

    logic [REC_W-1:0] mem [MAX_RECORDS];

    state_t           state_reg, state_next;
    algo_t            algo_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, m_reg, m_next;
    logic [REC_W-1:0] a_reg, a_next, b_reg, b_next;   // operand records
    logic [REC_W-1:0] rd_reg;
    logic             swap_reg, swap_next;
    logic             ov_reg, ov_next;
    logic [REC_W-1:0] od_reg;
    logic             ol_reg;
    logic             we;
    logic [IDX_W-1:0] wa, ra;
    logic [REC_W-1:0] wd;
    logic             out_take;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;
    assign m_axis_tuser  = ovf_reg;
    assign out_take      = ov_reg & m_axis_tready;

    // write-first: a read of the address being written returns the new word
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (we && wa == ra)
            rd_reg <= wd;
        else
            rd_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            algo_reg  <= ALGO_BUBBLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
            if (cfg_we)
                algo_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        m_reg    <= m_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        swap_reg <= swap_next;
        if (state_reg == ST_OUT_RD)
        begin
            od_reg <= rd_reg;
            ol_reg <= ({1'b0, i_reg} == cnt_reg - 1'b1);
        end
    end

    logic [CNT_W-1:0] n1;
    logic [CNT_W-1:0] bub_lim;
    assign n1      = cnt_reg - 1'b1;
    assign bub_lim = n1 - {1'b0, i_reg};

    // sequencer
    // bubble: RD_A j, RD_B j+1, CMP, WR j / j+1 when swapped
    // selection: A = min record (addr m), B = record j; at end swap i,m
    // insertion: A = key held (record i), B = record j-1; shift up
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        m_next     = m_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        swap_next  = swap_reg;
        ov_next    = ov_reg;
        we         = 1'b0;
        wa         = '0;
        wd         = '0;
        ra         = '0;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_axis_tvalid)
                begin
                    if (cnt_reg < CNT_W'(MAX_RECORDS))
                    begin
                        we       = 1'b1;
                        wa       = cnt_reg[IDX_W-1:0];
                        wd       = s_axis_tdata;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                        ovf_next = 1'b1;
                    if (s_axis_tlast)
                    begin
                        i_next = '0;
                        if (algo_reg == ALGO_NONE || cnt_next < CNT_W'(2))
                            state_next = (cnt_next == '0) ? ST_LOAD : ST_OUT_RD;
                        else
                        begin
                            if (algo_reg == ALGO_INSERTION)
                            begin
                                i_next = IDX_W'(1);
                                j_next = IDX_W'(1);
                                ra     = IDX_W'(1);
                            end
                            else
                            begin
                                j_next = (algo_reg == ALGO_SELECTION) ? IDX_W'(1) : '0;
                                m_next = '0;
                            end
                            state_next = ST_RD_A;
                        end
                        if (cnt_next == '0)
                            ovf_next = 1'b0;
                    end
                end
                ra = i_next;
            end
            ST_RD_A:
            begin
                // issue read of first operand
                case (algo_reg)
                    ALGO_SELECTION: ra = m_reg;
                    ALGO_INSERTION: ra = i_reg;
                    default:        ra = j_reg;
                endcase
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                a_next = rd_reg;
                case (algo_reg)
                    ALGO_SELECTION: ra = j_reg;
                    ALGO_INSERTION: ra = j_reg - 1'b1;
                    default:        ra = j_reg + 1'b1;
                endcase
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                b_next = rd_reg;
                // single shared comparator
                case (algo_reg)
                    ALGO_INSERTION:
                        swap_next = key_gt(rd_reg[KEY_W-1:0], a_reg[KEY_W-1:0]);
                    default:
                        swap_next = key_gt(a_reg[KEY_W-1:0], rd_reg[KEY_W-1:0]);
                endcase
                state_next = ST_WR_A;
            end
            ST_WR_A:
            begin
                case (algo_reg)
                    ALGO_BUBBLE:
                    begin
                        if (swap_reg)
                        begin
                            we = 1'b1;
                            wa = j_reg;
                            wd = b_reg;
                        end
                        state_next = ST_WR_B;
                    end
                    ALGO_SELECTION:
                    begin
                        if (swap_reg)
                        begin
                            m_next = j_reg;
                            a_next = b_reg;
                        end
                        // record i is in rd_reg when the scan ends
                        ra         = i_reg;
                        state_next = ST_NEXT;
                    end
                    default:
                    begin
                        // insertion: shift record j-1 up, or place key at j
                        we = 1'b1;
                        wa = j_reg;
                        if (swap_reg)
                        begin
                            wd     = b_reg;
                            j_next = j_reg - 1'b1;
                            if (j_reg == IDX_W'(1))
                                state_next = ST_WR_B;
                            else
                            begin
                                ra         = j_reg - 2'd2;
                                state_next = ST_CMP;
                            end
                        end
                        else
                        begin
                            wd         = a_reg;
                            state_next = ST_NEXT;
                        end
                    end
                endcase
            end
            ST_WR_B:
            begin
                we = 1'b1;
                case (algo_reg)
                    ALGO_BUBBLE:
                    begin
                        we = swap_reg;
                        wa = j_reg + 1'b1;
                        wd = a_reg;
                        state_next = ST_NEXT;
                    end
                    ALGO_SELECTION:
                    begin
                        // write min to i (swap second half)
                        wa = i_reg;
                        wd = a_reg;
                        state_next = ST_NEXT;
                    end
                    default:
                    begin
                        wa = '0;
                        wd = a_reg;
                        state_next = ST_NEXT;
                    end
                endcase
            end
            ST_NEXT:
            begin
                state_next = ST_RD_A;
                case (algo_reg)
                    ALGO_BUBBLE:
                    begin
                        if ({1'b0, j_reg} + 1'b1 < bub_lim)
                            j_next = j_reg + 1'b1;
                        else if ({1'b0, i_reg} + 2'd2 < cnt_reg)
                        begin
                            i_next = i_reg + 1'b1;
                            j_next = '0;
                        end
                        else
                            state_next = ST_OUT_RD;
                    end
                    ALGO_SELECTION:
                    begin
                        if (j_reg == i_reg)
                        begin
                            // swap done: next pass
                            if ({1'b0, i_reg} + 2'd2 < cnt_reg)
                            begin
                                i_next = i_reg + 1'b1;
                                m_next = i_reg + 1'b1;
                                j_next = i_reg + 2'd2;
                            end
                            else
                                state_next = ST_OUT_RD;
                        end
                        else if ({1'b0, j_reg} + 1'b1 < cnt_reg)
                            j_next = j_reg + 1'b1;
                        else
                        begin
                            // scan done: write old i into m, then min into i
                            we     = 1'b1;
                            wa     = m_reg;
                            wd     = rd_reg;
                            j_next = i_reg;
                            state_next = ST_WR_B;
                        end
                    end
                    default:
                    begin
                        if ({1'b0, i_reg} + 1'b1 < cnt_reg)
                        begin
                            i_next = i_reg + 1'b1;
                            j_next = i_reg + 1'b1;
                        end
                        else
                            state_next = ST_OUT_RD;
                    end
                endcase
                if (state_next == ST_OUT_RD)
                begin
                    i_next = '0;
                    ra     = '0;
                end
            end
            ST_OUT_RD:
            begin
                // rd_reg holds record i; loaded into output register
                ov_next    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                ra = i_reg + 1'b1;
                if (out_take)
                begin
                    ov_next = 1'b0;
                    if ({1'b0, i_reg} + 1'b1 == cnt_reg)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
                else
                    ra = i_reg;
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

`ifndef SYNTHESIS
    a_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while output pending");
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count above capacity");
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("no return to load after final word");
`endif

endmodule
